FILE: hdl/rdw_pkg.sv
// Shared types and constants for the radix digit writer.
// No dependencies; imported by the writer unit, the divider and the testbench.
`default_nettype none

package rdw_pkg;

	// request action codes
	localparam logic [1:0] ACT_CLEAR   = 2'd0;
	localparam logic [1:0] ACT_APPEND  = 2'd1;
	localparam logic [1:0] ACT_CONVERT = 2'd2;

	// symbols that may not sit in an alphabet
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;

	localparam int CNT_W   = 9;   // symbol count, 0..256
	localparam int MAG_W   = 32;  // magnitude / dividend width
	localparam int STK_AW  = 5;   // digit stack address, 32 entries
	localparam int ND_W    = 6;   // digit count, 0..32

	typedef struct packed {
		logic [1:0]        action;
		logic [7:0]        symbol;
		logic signed [31:0] number;
	} req_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       final_char;
		logic       invalid_base;
	} res_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [MAG_W-1:0] quotient;
		logic [CNT_W-1:0] remainder;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: hdl/radix_digit_writer_unit.sv
// Radix digit writer: one request at a time. A convert emits the sign first
// when negative, divides by the radix in the bit-serial divider once per
// digit, pushing each remainder on the digit stack, then pops the digits
// and reads each one's symbol from the alphabet.
// Results leave through a one-entry output register; a stalled result holds
// the sequencer only when the next character is due.
// Reset (arst_n, async low) empties the alphabet and clears the seen map.
`default_nettype none

module radix_digit_writer_unit #(
	parameter int MAX_SYMBOLS = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rdw_pkg::req_t req_data,
	output logic               res_valid,
	input  wire logic          res_stall,
	output rdw_pkg::res_t      res_data
);
	import rdw_pkg::*;

	localparam int TAB_AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SYMBOLS);

	typedef enum logic [3:0] {
		S_IDLE,
		S_AP_SEEN,   // seen map data back, fetch alphabet entry it points at
		S_AP_TAB,    // alphabet entry back, decide duplicate, write both memories
		S_BAD,       // emit the invalid-base result
		S_MINUS,     // emit the sign
		S_DIV_GO,    // start one division by the radix
		S_DIV_WAIT,  // wait for the divider, push remainder digit
		S_EM_STK,    // read top of the digit stack
		S_EM_TAB,    // map digit value to symbol
		S_EM_OUT     // hand character to the output register
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic             bad_q;
	logic [7:0]       sym_q;
	logic [MAG_W-1:0] mag_q;
	logic [ND_W-1:0]  nd_q;
	logic             out_valid_q;
	res_t             out_q;

	// digit stack: digit values of the running conversion, least significant first
	logic [TAB_AW-1:0] stk_mem [2**STK_AW];
	logic [TAB_AW-1:0] stk_rd_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [MAG_W-1:0]  num_u;
	logic [ND_W-1:0]   nd_m1;
	logic              seen_rd_en;
	logic              seen_hit;
	logic [TAB_AW-1:0] seen_pos;
	logic              mem_wr_en;
	logic              tab_rd_en;
	logic [TAB_AW-1:0] tab_rd_addr;
	logic [7:0]        tab_rd_data;
	logic              dup;
	logic              div_start;
	div_stat_t         div_stat;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !res_stall;
	// a character enters the output register this cycle
	assign out_load  = out_free && (state_q inside {S_BAD, S_MINUS, S_EM_OUT});
	assign num_u     = req_data.number;
	assign nd_m1     = nd_q - 1'b1;

	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	// Memory accesses never overlap on one entry: the sequencer finishes each
	// read-modify-write before the next request is taken.
	always_comb begin
		seen_rd_en  = accept && (req_data.action == ACT_APPEND) && (count_q < MAX_CNT);
		mem_wr_en   = (state_q == S_AP_TAB);
		tab_rd_en   = (state_q == S_AP_SEEN) || (state_q == S_EM_TAB);
		tab_rd_addr = (state_q == S_AP_SEEN) ? seen_pos : stk_rd_q;
		div_start   = (state_q == S_DIV_GO);
		// a symbol is a duplicate when its last recorded position is still
		// inside the current alphabet and still holds that symbol
		dup = seen_hit && (CNT_W'(seen_pos) < count_q) && (tab_rd_data == sym_q);
	end

	rdw_seen_mem #(
		.AW(TAB_AW)
	) u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (seen_rd_en),
		.rd_sym (req_data.symbol),
		.wr_en  (mem_wr_en),
		.wr_sym (sym_q),
		.wr_pos (count_q[TAB_AW-1:0]),
		.rd_hit (seen_hit),
		.rd_pos (seen_pos)
	);

	rdw_sym_mem #(
		.MAX_SYMBOLS(MAX_SYMBOLS),
		.AW         (TAB_AW)
	) u_sym (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (count_q[TAB_AW-1:0]),
		.wr_data (sym_q),
		.rd_en   (tab_rd_en),
		.rd_addr (tab_rd_addr),
		.rd_data (tab_rd_data)
	);

	rdw_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (count_q),
		.stat     (div_stat)
	);

	// digit stack write on each finished division, registered read on pop
	always_ff @(posedge clk) begin
		if ((state_q == S_DIV_WAIT) && div_stat.done) begin
			stk_mem[nd_q[STK_AW-1:0]] <= div_stat.remainder[TAB_AW-1:0];
		end
		if (state_q == S_EM_STK) begin
			stk_rd_q <= stk_mem[nd_m1[STK_AW-1:0]];
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			bad_q       <= 1'b0;
			sym_q       <= '0;
			mag_q       <= '0;
			nd_q        <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_data.action)
							ACT_CLEAR: begin
								count_q <= '0;
								bad_q   <= 1'b0;
							end
							ACT_APPEND: begin
								// full alphabet drops the symbol
								if (count_q < MAX_CNT) begin
									sym_q   <= req_data.symbol;
									state_q <= S_AP_SEEN;
								end
							end
							ACT_CONVERT: begin
								nd_q  <= '0;
								// two's complement negate also covers the most negative value
								mag_q <= num_u[MAG_W-1] ? (MAG_W'(0) - num_u) : num_u;
								if (bad_q || (count_q < CNT_W'(2))) begin
									state_q <= S_BAD;
								end else if (num_u[MAG_W-1]) begin
									state_q <= S_MINUS;
								end else begin
									state_q <= S_DIV_GO;
								end
							end
							default: begin
								// reserved action: ignored
							end
						endcase
					end
				end
				S_AP_SEEN: begin
					state_q <= S_AP_TAB;
				end
				S_AP_TAB: begin
					if (dup || (sym_q == SYM_PLUS) || (sym_q == SYM_MINUS)) begin
						bad_q <= 1'b1;
					end
					count_q <= count_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_BAD: begin
					if (out_free) begin
						out_q       <= '{out_char: 8'h00, final_char: 1'b0, invalid_base: 1'b1};
						state_q     <= S_IDLE;
					end
				end
				S_MINUS: begin
					if (out_free) begin
						out_q       <= '{out_char: SYM_MINUS, final_char: 1'b0, invalid_base: 1'b0};
						state_q     <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_stat.done) begin
						nd_q  <= nd_q + 1'b1;
						mag_q <= div_stat.quotient;
						if ((div_stat.quotient == '0) || (nd_q == ND_W'(2**STK_AW - 1))) begin
							state_q <= S_EM_STK;
						end else begin
							state_q <= S_DIV_GO;
						end
					end
				end
				S_EM_STK: begin
					nd_q    <= nd_m1;
					state_q <= S_EM_TAB;
				end
				S_EM_TAB: begin
					state_q <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (out_free) begin
						out_q       <= '{out_char: tab_rd_data, final_char: (nd_q == '0),
						                 invalid_base: 1'b0};
						state_q     <= (nd_q == '0) ? S_IDLE : S_EM_STK;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// alphabet never grows past its capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("symbol count beyond capacity");

	// a convert request keeps the block busy for at least the next cycle
	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_data.action == ACT_CONVERT)) |=> req_stall)
		else $error("convert request did not hold the block busy");

	// an invalid-base result carries no character and no final mark
	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.invalid_base) |->
		((res_data.out_char == 8'h00) && !res_data.final_char))
		else $error("malformed invalid-base result");

	// divider is only restarted once the previous division is over
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: hdl/rdw_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rdw_pkg (div_stat_t, widths).
`default_nettype none

module rdw_divider (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [rdw_pkg::MAG_W-1:0] dividend,
	input  wire logic [rdw_pkg::CNT_W-1:0] divisor,
	output rdw_pkg::div_stat_t            stat
);
	import rdw_pkg::*;

	localparam int STEP_W = $clog2(MAG_W);

	logic             busy_q;
	logic             done_q;
	logic [STEP_W-1:0] step_q;
	logic [MAG_W-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] shifted;
	logic             fits;

	// remainder stays below divisor (<= 256), so its low 8 bits carry it
	assign shifted = {rem_q[CNT_W-2:0], quo_q[MAG_W-1]};
	assign fits    = (shifted >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (step_q == STEP_W'(MAG_W - 1))) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			step_q <= '0;
		end else if (busy_q) begin
			quo_q  <= {quo_q[MAG_W-2:0], fits};
			rem_q  <= fits ? (shifted - divisor) : shifted;
			step_q <= step_q + 1'b1;
		end
	end

	assign stat = '{busy: busy_q, done: done_q, quotient: quo_q, remainder: rem_q};

endmodule

`default_nettype wire

FILE: hdl/rdw_sym_mem.sv
// Alphabet memory: symbol byte per digit value, one write and one read port.
// Read data is registered. Depends on nothing else.
`default_nettype none

module rdw_sym_mem #(
	parameter int MAX_SYMBOLS = 256,
	parameter int AW          = 8
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic [7:0]         rd_data
);

	logic [7:0] mem [MAX_SYMBOLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/rdw_seen_mem.sv
// Seen map: per symbol byte, the alphabet position it was last appended at,
// plus a valid bit per byte cleared at reset. Registered read. No package use.
`default_nettype none

module rdw_seen_mem #(
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [7:0]    rd_sym,
	input  wire logic          wr_en,
	input  wire logic [7:0]    wr_sym,
	input  wire logic [AW-1:0] wr_pos,
	output logic               rd_hit,
	output logic [AW-1:0]      rd_pos
);

	logic [AW-1:0] pos_mem [256];
	logic [255:0]  vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rd_hit <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_sym] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit <= vld_q[rd_sym];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			pos_mem[wr_sym] <= wr_pos;
		end
		if (rd_en) begin
			rd_pos <= pos_mem[rd_sym];
		end
	end

endmodule

`default_nettype wire

FILE: sim/radix_digit_writer_unit_tb.sv
// Testbench for radix_digit_writer_unit: request driver, result monitor and character predictor.
// Depends on rdw_pkg (hdl/rdw_pkg.sv) and the radix_digit_writer_unit RTL.
// Self-checking. Prints each mismatch and the final verdict.
module radix_digit_writer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rdw_pkg::*;

	localparam int          ALPHA_MAX    = 256;
	localparam int          RND_ITEMS    = 40;
	localparam int          DRAIN_CYCLES = 1200;   // quiet tail after all characters are back
	localparam logic [1:0]  ACT_RESERVED = 2'd3;   // undefined action, block ignores it
	localparam logic [31:0] INT_MIN      = 32'h8000_0000;
	localparam logic [31:0] INT_MAX      = 32'h7FFF_FFFF;

	// one queued request plus the idle cycles the sender spends before it;
	// hold makes the sender wait until every pending character has come back
	typedef struct packed {
		req_t       req;
		logic [3:0] gap;
		logic       hold;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;

	stim_t stim_q[$];      // requests not yet presented
	res_t  char_q[$];      // characters predicted and not yet received
	int    gap_wait;       // idle cycles spent before the head request
	int    stall_left;     // stall cycles left for the current/next character
	int    stall_next;
	int    stim_n;         // requests queued so far, sets quiet stretches
	int    chars_seen;
	int    errors = 0;

	// predictor's copy of the alphabet
	logic [7:0]  alpha_sym [256];
	logic [255:0] alpha_used = '0;
	logic [8:0]  alpha_len = '0;
	logic        alpha_bad = 1'b0;

	radix_digit_writer_unit #(
		.MAX_SYMBOLS(ALPHA_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always #5 clk = ~clk;

	// Apply one accepted request to the alphabet and queue the characters it prints.
	function automatic void predict_chars(input req_t r);
		logic [31:0] mag;
		logic [31:0] radix;
		logic [7:0]  digits [32];
		res_t        c;
		int          nd;
		nd = 0;
		case (r.action)
			ACT_CLEAR: begin
				alpha_used = '0;
				alpha_len = '0;
				alpha_bad = 1'b0;
			end
			ACT_APPEND: begin
				// full alphabet: symbol is dropped
				if (alpha_len < ALPHA_MAX) begin
					if (r.symbol == SYM_PLUS || r.symbol == SYM_MINUS || alpha_used[r.symbol])
						alpha_bad = 1'b1;
					alpha_used[r.symbol] = 1'b1;
					alpha_sym[alpha_len[7:0]] = r.symbol;
					alpha_len = alpha_len + 9'd1;
				end
			end
			ACT_CONVERT: begin
				radix = {23'd0, alpha_len};
				if (alpha_bad || radix < 2) begin
					c = '{out_char: 8'h00, final_char: 1'b0, invalid_base: 1'b1};
					char_q.push_back(c);
				end else begin
					if (r.number[31]) begin
						c = '{out_char: SYM_MINUS, final_char: 1'b0, invalid_base: 1'b0};
						char_q.push_back(c);
						mag = 32'd0 - r.number;   // 2^31 wraps to itself, read unsigned
					end else begin
						mag = r.number;
					end
					// least significant digit first, then unwind
					do begin
						digits[nd] = alpha_sym[8'(mag % radix)];
						nd++;
						mag = mag / radix;
					end while (mag != 0 && nd < 32);
					for (int k = nd - 1; k >= 0; k--) begin
						c = '{out_char: digits[k], final_char: (k == 0), invalid_base: 1'b0};
						char_q.push_back(c);
					end
				end
			end
			default: begin
				// reserved action: no change, nothing printed
			end
		endcase
	endfunction

	// Queue a request. Fields the action does not use carry random bits.
	function automatic void add_req(input logic [1:0] act, input logic [7:0] sym,
			input logic [31:0] num, input logic hold);
		stim_t s;
		s.req.action = act;
		s.req.symbol = (act == ACT_APPEND) ? sym : 8'($urandom);
		s.req.number = (act == ACT_CONVERT) ? num : $urandom;
		// every fourth stretch of 25 requests goes back to back
		s.gap = ((stim_n / 25) % 4 == 3) ? 4'd0 : 4'($urandom_range(0, 15));
		s.hold = hold;
		stim_q.push_back(s);
		stim_n++;
	endfunction

	function automatic logic [31:0] pick_number();
		int r;
		r = $urandom_range(0, 7);
		case (r)
			0: begin
				case ($urandom_range(0, 4))
					0: return INT_MIN;
					1: return INT_MAX;
					2: return 32'hFFFF_FFFF;
					3: return 32'd1;
					default: return 32'd0;
				endcase
			end
			1, 2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	// Request driver. Prediction runs at the edge where a request is taken,
	// so expectations always precede the characters they cover.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
			gap_wait <= 0;
		end else begin
			if (req_valid && !req_stall)
				predict_chars(req_data);
			// slot is free unless a request is still held by stall
			if (!req_valid || !req_stall) begin
				if (stim_q.size() != 0 && gap_wait >= stim_q[0].gap
						&& (!stim_q[0].hold || char_q.size() == 0)) begin
					req_data <= stim_q[0].req;
					req_valid <= 1'b1;
					gap_wait <= 0;
					void'(stim_q.pop_front());
				end else begin
					req_valid <= 1'b0;
					if (stim_q.size() != 0 && gap_wait < stim_q[0].gap)
						gap_wait <= gap_wait + 1;
				end
			end
		end
	end

	// Result monitor. After each character a stall length is drawn; it only
	// counts down while a character is offered, so every character can be held.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
			chars_seen <= 0;
		end else begin
			stall_next = stall_left;
			if (res_valid && !res_stall) begin
				if (char_q.size() == 0) begin
					$display("%0t: unexpected character, got out_char=%h final=%b invalid=%b",
						$time, res_data.out_char, res_data.final_char,
						res_data.invalid_base);
					errors++;
				end else begin
					if (res_data.out_char !== char_q[0].out_char
							|| res_data.final_char !== char_q[0].final_char
							|| res_data.invalid_base !== char_q[0].invalid_base) begin
						$display("%0t: mismatch, expected out_char=%h final=%b invalid=%b, got out_char=%h final=%b invalid=%b",
							$time, char_q[0].out_char, char_q[0].final_char,
							char_q[0].invalid_base, res_data.out_char,
							res_data.final_char, res_data.invalid_base);
						errors++;
					end
					void'(char_q.pop_front());
				end
				chars_seen <= chars_seen + 1;
				// quiet stretch: every third block of 40 characters is never stalled
				stall_next = ((chars_seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 15);
			end else if (res_valid && stall_left != 0) begin
				stall_next = stall_left - 1;
			end
			stall_left <= stall_next;
			res_stall <= (stall_next != 0);
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		logic [7:0] pool [254];
		logic [7:0] sym;
		logic [7:0] tmp;
		int         n;
		int         j;
		int         radix;
		int         flaw_at;
		int         rnd_items;
		int         sel;
		int         settle;

		stim_n = 0;
		rnd_items = 0;

		// ---- directed part ----
		add_req(ACT_CONVERT, 8'h00, 32'd0, 1'b0);       // empty alphabet after reset
		add_req(ACT_RESERVED, 8'h00, 32'd0, 1'b0);
		add_req(ACT_CLEAR, 8'h00, 32'd0, 1'b0);
		add_req(ACT_APPEND, "0", 32'd0, 1'b0);
		add_req(ACT_CONVERT, 8'h00, 32'd7, 1'b0);       // one symbol: still invalid
		add_req(ACT_APPEND, "1", 32'd0, 1'b0);
		add_req(ACT_CONVERT, 8'h00, 32'd0, 1'b0);       // zero prints one digit
		add_req(ACT_CONVERT, 8'h00, 32'hFFFF_FFFF, 1'b0);
		add_req(ACT_CONVERT, 8'h00, INT_MIN, 1'b0);     // sign plus 32 binary digits
		add_req(ACT_CONVERT, 8'h00, INT_MAX, 1'b0);
		add_req(ACT_RESERVED, 8'h2B, 32'd0, 1'b0);      // must not touch the alphabet
		add_req(ACT_CONVERT, 8'h00, 32'd5, 1'b0);
		add_req(ACT_APPEND, SYM_PLUS, 32'd0, 1'b0);
		add_req(ACT_CONVERT, 8'h00, 32'd3, 1'b0);
		add_req(ACT_CLEAR, 8'h00, 32'd0, 1'b1);         // sender drains before this one
		add_req(ACT_APPEND, 8'h00, 32'd0, 1'b0);        // byte zero is an ordinary symbol
		add_req(ACT_APPEND, 8'hFF, 32'd0, 1'b0);
		add_req(ACT_APPEND, 8'h7F, 32'd0, 1'b0);
		add_req(ACT_CONVERT, 8'h00, -32'sd8, 1'b0);
		add_req(ACT_APPEND, 8'h00, 32'd0, 1'b0);        // duplicate
		add_req(ACT_CONVERT, 8'h00, 32'd1, 1'b0);
		add_req(ACT_CLEAR, 8'h00, 32'd0, 1'b0);
		add_req(ACT_APPEND, SYM_MINUS, 32'd0, 1'b0);
		add_req(ACT_CONVERT, 8'h00, 32'd0, 1'b0);

		// pool of every byte except the sign characters
		n = 0;
		for (int i = 0; i < 256; i++)
			if (8'(i) != SYM_PLUS && 8'(i) != SYM_MINUS) begin
				pool[n] = 8'(i);
				n++;
			end

		// radix above 128: remainders use the top digit bit
		add_req(ACT_CLEAR, 8'h00, 32'd0, 1'b0);
		for (int i = 0; i < 130; i++)
			add_req(ACT_APPEND, pool[i], 32'd0, 1'b0);
		add_req(ACT_CONVERT, 8'h00, INT_MIN, 1'b0);
		add_req(ACT_CONVERT, 8'h00, INT_MAX, 1'b0);
		add_req(ACT_CONVERT, 8'h00, 32'd129, 1'b0);
		add_req(ACT_CONVERT, 8'h00, 32'd130, 1'b0);

		// decimal
		add_req(ACT_CLEAR, 8'h00, 32'd0, 1'b0);
		for (int i = 0; i < 10; i++)
			add_req(ACT_APPEND, 8'h30 + 8'(i), 32'd0, 1'b0);
		add_req(ACT_CONVERT, 8'h00, INT_MIN, 1'b0);
		add_req(ACT_CONVERT, 8'h00, INT_MAX, 1'b0);
		add_req(ACT_CONVERT, 8'h00, -32'sd123456789, 1'b0);

		// ---- random part ----
		// mostly: clear, build a fresh alphabet, convert a few numbers;
		// some alphabets carry a sign or a duplicate, the rest is raw noise
		while (rnd_items < RND_ITEMS) begin
			if ($urandom_range(0, 9) < 8) begin
				for (int i = 253; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = pool[i];
					pool[i] = pool[j];
					pool[j] = tmp;
				end
				sel = $urandom_range(0, 29);
				if (sel == 0)
					radix = $urandom_range(41, 80);
				else if (sel < 8)
					radix = $urandom_range(2, 3);
				else if (sel < 22)
					radix = $urandom_range(4, 16);
				else
					radix = $urandom_range(17, 40);
				flaw_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, radix - 1) : -1;
				add_req(ACT_CLEAR, 8'h00, 32'd0, $urandom_range(0, 19) == 0);
				rnd_items++;
				for (int i = 0; i < radix; i++) begin
					sym = pool[i];
					if (i == flaw_at) begin
						case ($urandom_range(0, 2))
							0: sym = SYM_PLUS;
							1: sym = SYM_MINUS;
							default: sym = (i > 0) ? pool[$urandom_range(0, i - 1)] : SYM_PLUS;
						endcase
					end
					add_req(ACT_APPEND, sym, 32'd0, 1'b0);
					rnd_items++;
				end
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					add_req(ACT_CONVERT, 8'h00, pick_number(), 1'b0);
					rnd_items++;
				end
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					sel = $urandom_range(0, 3);
					add_req(2'(sel), 8'($urandom), pick_number(), 1'b0);
					if (2'(sel) != ACT_RESERVED)
						rnd_items++;
				end
			end
		end

		// release reset away from the clock edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all requests taken, all characters back, then a quiet tail
		while (stim_q.size() != 0 || req_valid)
			@(posedge clk);
		while (char_q.size() != 0)
			@(posedge clk);
		for (settle = 0; settle < DRAIN_CYCLES; settle++)
			@(posedge clk);

		if (errors == 0 && char_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#60_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: radix_digit_writer_unit.f
hdl/rdw_pkg.sv
hdl/rdw_divider.sv
hdl/rdw_sym_mem.sv
hdl/rdw_seen_mem.sv
hdl/radix_digit_writer_unit.sv
sim/radix_digit_writer_unit_tb.sv
